/* src/psc_pkg.sv */
// shared types, codes and the byte-wise crc-32/mpeg-2 update for the section checker
// no dependencies; used by every module under src
package psc_pkg;

    localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [11:0] HDR_CRC_BYTES = 12'd9;
    localparam logic [11:0] HDR_LAST_COUNT = 12'd7;
    localparam logic [11:0] LEN_CAPTURE_COUNT = 12'd2;
    localparam logic [11:0] CRC_LAST_COUNT = 12'd3;

    // parser phase
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_PAYLOAD,
        PH_CRC
    } phase_t;

    // result kind
    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_SUMMARY = 2'd1,
        KIND_LEN_ERR = 2'd2,
        KIND_RSVD    = 2'd3
    } kind_t;

    // one result record as it travels through the queue
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload_byte;
        logic [7:0]  table_id;
        logic        syntax_flag;
        logic        private_flag;
        logic [11:0] payload_length;
        logic [15:0] table_number;
        logic [4:0]  version;
        logic        current_next;
        logic [7:0]  section_number;
        logic [7:0]  last_section_number;
        logic        crc_ok;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    // crc-32/mpeg-2, msb first, one byte
    function automatic logic [31:0] crc_feed(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {b, 24'h000000};
        for (int i = 0; i < 8; i++) begin
            c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
        end
        return c;
    endfunction

endpackage

/* src/psc_front.sv */
// front end: section parser, header capture and running crc, one byte per cycle while in_accept is high
// depends on psc_pkg; hands result records to the queue
module psc_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_accept,
    input  logic [7:0]    in_byte,
    input  logic          in_start,
    output logic          rec_push,
    output psc_pkg::rec_t rec_data
);

    psc_pkg::phase_t phase_reg, phase_next;
    logic [11:0] byte_count_reg, byte_count_next;
    logic [7:0]  hdr_reg [8];
    logic [7:0]  hdr_next [8];
    logic [11:0] sec_len_reg, sec_len_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] rx_crc_reg, rx_crc_next;

    logic [11:0] cnt_inc;
    logic [11:0] plen;
    logic        len_short;
    logic [31:0] crc_fed;
    logic        hdr_done;
    logic        pay_done;
    logic        crc_done;

    assign cnt_inc   = byte_count_reg + 12'd1;
    assign len_short = sec_len_reg < psc_pkg::HDR_CRC_BYTES;
    assign plen      = len_short ? 12'd0 : sec_len_reg - psc_pkg::HDR_CRC_BYTES;
    assign crc_fed   = psc_pkg::crc_feed(crc_reg, in_byte);
    assign hdr_done  = byte_count_reg == psc_pkg::HDR_LAST_COUNT;
    assign pay_done  = cnt_inc >= plen;
    assign crc_done  = byte_count_reg == psc_pkg::CRC_LAST_COUNT;

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (in_accept) begin
            if (in_start) begin
                phase_next = psc_pkg::PH_HEADER;
            end else begin
                unique case (phase_reg)
                    psc_pkg::PH_IDLE: phase_next = psc_pkg::PH_IDLE;
                    psc_pkg::PH_HEADER: begin
                        if (hdr_done) begin
                            if (len_short) begin
                                phase_next = psc_pkg::PH_IDLE;
                            end else if (plen == 12'd0) begin
                                phase_next = psc_pkg::PH_CRC;
                            end else begin
                                phase_next = psc_pkg::PH_PAYLOAD;
                            end
                        end
                    end
                    psc_pkg::PH_PAYLOAD: begin
                        if (pay_done) begin
                            phase_next = psc_pkg::PH_CRC;
                        end
                    end
                    psc_pkg::PH_CRC: begin
                        if (crc_done) begin
                            phase_next = psc_pkg::PH_IDLE;
                        end
                    end
                    default: phase_next = psc_pkg::PH_IDLE;
                endcase
            end
        end
    end

    // datapath next values and result push
    always_comb begin
        byte_count_next = byte_count_reg;
        hdr_next        = hdr_reg;
        sec_len_next    = sec_len_reg;
        crc_next        = crc_reg;
        rx_crc_next     = rx_crc_reg;
        rec_push        = 1'b0;
        rec_data.kind   = psc_pkg::KIND_PAYLOAD;
        rec_data.payload_byte   = 8'd0;
        rec_data.payload_length = 12'd0;
        rec_data.crc_ok         = 1'b0;
        if (in_accept) begin
            if (in_start) begin
                for (int k = 0; k < 8; k++) begin
                    hdr_next[k] = 8'd0;
                end
                hdr_next[0]     = in_byte;
                sec_len_next    = 12'd0;
                rx_crc_next     = 32'd0;
                crc_next        = psc_pkg::crc_feed(psc_pkg::CRC_INIT, in_byte);
                byte_count_next = 12'd1;
            end else begin
                unique case (phase_reg)
                    psc_pkg::PH_IDLE: ;
                    psc_pkg::PH_HEADER: begin
                        hdr_next[byte_count_reg[2:0]] = in_byte;
                        crc_next        = crc_fed;
                        byte_count_next = cnt_inc;
                        if (byte_count_reg == psc_pkg::LEN_CAPTURE_COUNT) begin
                            sec_len_next = {hdr_reg[1][3:0], in_byte};
                        end
                        if (hdr_done) begin
                            byte_count_next = 12'd0;
                            if (len_short) begin
                                rec_push      = 1'b1;
                                rec_data.kind = psc_pkg::KIND_LEN_ERR;
                            end
                        end
                    end
                    psc_pkg::PH_PAYLOAD: begin
                        crc_next        = crc_fed;
                        byte_count_next = pay_done ? 12'd0 : cnt_inc;
                        rec_push        = 1'b1;
                        rec_data.kind   = psc_pkg::KIND_PAYLOAD;
                        rec_data.payload_byte   = in_byte;
                        rec_data.payload_length = plen;
                    end
                    psc_pkg::PH_CRC: begin
                        rx_crc_next     = {rx_crc_reg[23:0], in_byte};
                        byte_count_next = crc_done ? 12'd0 : cnt_inc;
                        if (crc_done) begin
                            rec_push      = 1'b1;
                            rec_data.kind = psc_pkg::KIND_SUMMARY;
                            rec_data.payload_length = plen;
                            rec_data.crc_ok = hdr_reg[1][7] &&
                                              ({rx_crc_reg[23:0], in_byte} == crc_reg);
                        end
                    end
                    default: ;
                endcase
            end
        end
        // header fields as they stand after this byte
        rec_data.table_id            = hdr_next[0];
        rec_data.syntax_flag         = hdr_next[1][7];
        rec_data.private_flag        = hdr_next[1][6];
        rec_data.table_number        = {hdr_next[3], hdr_next[4]};
        rec_data.version             = hdr_next[5][5:1];
        rec_data.current_next        = hdr_next[5][0];
        rec_data.section_number      = hdr_next[6];
        rec_data.last_section_number = hdr_next[7];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= psc_pkg::PH_IDLE;
            byte_count_reg <= 12'd0;
            sec_len_reg    <= 12'd0;
            crc_reg        <= psc_pkg::CRC_INIT;
            rx_crc_reg     <= 32'd0;
            for (int k = 0; k < 8; k++) begin
                hdr_reg[k] <= 8'd0;
            end
        end else begin
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            sec_len_reg    <= sec_len_next;
            crc_reg        <= crc_next;
            rx_crc_reg     <= rx_crc_next;
            hdr_reg        <= hdr_next;
        end
    end

endmodule

/* src/psc_fifo.sv */
// short result queue between parser and output stage
// depends on psc_pkg for the record type
module psc_fifo #(
    parameter int DEPTH = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  psc_pkg::rec_t push_data,
    input  logic          pop,
    output psc_pkg::rec_t pop_data,
    output logic          full,
    output logic          empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    psc_pkg::rec_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign full     = count_reg == CNT_FULL;
    assign empty    = count_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        priority if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end else begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* src/psc_back.sv */
// back end: pulls records from the queue into the output register and packs the stream
// depends on psc_pkg for the record type and kind codes
module psc_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_empty,
    input  psc_pkg::rec_t q_data,
    output logic          q_pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [71:0]   m_tdata,
    output logic [1:0]    m_tuser
);

    logic          valid_reg, valid_next;
    psc_pkg::rec_t out_reg;

    // load when the output register is free or being taken
    assign q_pop = !q_empty && (!valid_reg || m_tready);

    always_comb begin
        valid_next = valid_reg;
        if (q_pop) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_reg <= q_data;
        end
    end

    // stream packing
    assign m_tvalid = valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {3'b000,
                       out_reg.crc_ok,
                       out_reg.last_section_number,
                       out_reg.section_number,
                       out_reg.current_next,
                       out_reg.version,
                       out_reg.table_number,
                       out_reg.payload_length,
                       out_reg.private_flag,
                       out_reg.syntax_flag,
                       out_reg.table_id,
                       out_reg.payload_byte};

endmodule

/* src/psi_section_header_crc_check.sv */
// psi section parser with crc-32/mpeg-2 check: one byte accepted per cycle, sustained while the queue has room
// m_tvalid rises once the record caused by an accepted byte has been written into the result queue
// and then loaded from the queue into the output register
// throughput: one byte per cycle; the parser stalls only when the result queue is full
// the result queue holds QUEUE_DEPTH records between parser and output register
// reset: synchronous active-low aresetn, parser idle waiting for a start byte, queue empty
// depends on psc_pkg, psc_front, psc_fifo, psc_back
module psi_section_header_crc_check #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] start_req
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] payload_byte, [15:8] table_id, [16] syntax_flag, [17] private_flag,
    // [29:18] payload_length, [45:30] table_number, [50:46] version,
    // [51] current_next, [59:52] section_number, [67:60] last_section_number,
    // [68] crc_ok, [71:69] zero
    output logic [71:0] m_tdata,
    output logic [1:0]  m_tuser    // [1:0] kind
);

    logic          in_accept;
    logic          rec_push;
    psc_pkg::rec_t rec_data;
    logic          q_full;
    logic          q_empty;
    logic          q_pop;
    psc_pkg::rec_t q_data;

    assign s_tready  = !q_full;
    assign in_accept = s_tvalid && s_tready;

    // parser
    psc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .in_start  (s_tuser),
        .rec_push  (rec_push),
        .rec_data  (rec_data)
    );

    // result queue
    psc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (rec_push),
        .push_data (rec_data),
        .pop       (q_pop),
        .pop_data  (q_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    // output stage
    psc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

/* dv/psi_section_checker.sv */
// request monitor and result checker for the psi section parser, plus a shared crc helper
// depends on psc_pkg for the kind and phase codes and the header constants
`timescale 1ns / 1ps

package section_tb_pkg;

    // crc-32/mpeg-2 advanced by one byte, one input bit at a time, msb first
    function automatic logic [31:0] crc_next(input logic [31:0] crc, input logic [7:0] d);
        logic [31:0] r;
        r = crc;
        for (int i = 7; i >= 0; i--) begin
            r = {r[30:0], 1'b0} ^ ((r[31] ^ d[i]) ? psc_pkg::CRC_POLY : 32'h0);
        end
        return r;
    endfunction
endpackage

module psi_section_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    input  logic [1:0]  m_tuser,
    output int          mismatches,
    output int          outstanding
);

    typedef struct packed {
        psc_pkg::kind_t kind;
        logic [7:0]     payload_byte;
        logic [7:0]     table_id;
        logic           syntax_flag;
        logic           private_flag;
        logic [11:0]    payload_length;
        logic [15:0]    table_number;
        logic [4:0]     version;
        logic           current_next;
        logic [7:0]     section_number;
        logic [7:0]     last_section_number;
        logic           crc_ok;
    } section_record_t;

    section_record_t due_records[$];

    // predicted parser state
    psc_pkg::phase_t parse_phase;
    logic [11:0]     byte_cnt;
    logic [7:0]      hdr_bytes [8];
    logic [11:0]     sec_length;
    logic [31:0]     crc_calc;
    logic [31:0]     crc_rcvd;
    int              err_cnt = 0;

    function automatic logic [11:0] payload_len_now();
        return (sec_length >= psc_pkg::HDR_CRC_BYTES) ?
               sec_length - psc_pkg::HDR_CRC_BYTES : 12'd0;
    endfunction

    // every record carries the header of the current section
    task automatic queue_record(input psc_pkg::kind_t k, input logic [7:0] pb,
                                input logic c_ok);
        section_record_t r;
        r.kind                = k;
        r.payload_byte        = pb;
        r.table_id            = hdr_bytes[0];
        r.syntax_flag         = hdr_bytes[1][7];
        r.private_flag        = hdr_bytes[1][6];
        r.payload_length      = payload_len_now();
        r.table_number        = {hdr_bytes[3], hdr_bytes[4]};
        r.version             = hdr_bytes[5][5:1];
        r.current_next        = hdr_bytes[5][0];
        r.section_number      = hdr_bytes[6];
        r.last_section_number = hdr_bytes[7];
        r.crc_ok              = c_ok;
        due_records.push_back(r);
    endtask

    // advance the predicted parser by one accepted byte
    task automatic parse_byte(input logic [7:0] d, input logic st);
        if (st) begin
            // a start byte always aborts whatever is in progress
            for (int k = 0; k < 8; k++) hdr_bytes[k] = 8'h00;
            hdr_bytes[0] = d;
            sec_length   = 12'd0;
            crc_rcvd     = 32'h0;
            crc_calc     = section_tb_pkg::crc_next(psc_pkg::CRC_INIT, d);
            byte_cnt     = 12'd1;
            parse_phase  = psc_pkg::PH_HEADER;
        end else begin
            case (parse_phase)
                psc_pkg::PH_HEADER: begin
                    hdr_bytes[byte_cnt[2:0]] = d;
                    crc_calc = section_tb_pkg::crc_next(crc_calc, d);
                    byte_cnt = byte_cnt + 12'd1;
                    if (byte_cnt == 12'd3)
                        sec_length = {hdr_bytes[1][3:0], hdr_bytes[2]};
                    if (byte_cnt >= 12'd8) begin
                        byte_cnt = 12'd0;
                        if (sec_length < psc_pkg::HDR_CRC_BYTES) begin
                            parse_phase = psc_pkg::PH_IDLE;
                            queue_record(psc_pkg::KIND_LEN_ERR, 8'h00, 1'b0);
                        end else begin
                            parse_phase = (payload_len_now() == 12'd0) ?
                                          psc_pkg::PH_CRC : psc_pkg::PH_PAYLOAD;
                        end
                    end
                end
                psc_pkg::PH_PAYLOAD: begin
                    crc_calc = section_tb_pkg::crc_next(crc_calc, d);
                    byte_cnt = byte_cnt + 12'd1;
                    if (byte_cnt >= payload_len_now()) begin
                        byte_cnt    = 12'd0;
                        parse_phase = psc_pkg::PH_CRC;
                    end
                    queue_record(psc_pkg::KIND_PAYLOAD, d, 1'b0);
                end
                psc_pkg::PH_CRC: begin
                    crc_rcvd = {crc_rcvd[23:0], d};
                    byte_cnt = byte_cnt + 12'd1;
                    if (byte_cnt >= 12'd4) begin
                        byte_cnt    = 12'd0;
                        parse_phase = psc_pkg::PH_IDLE;
                        queue_record(psc_pkg::KIND_SUMMARY, 8'h00,
                                     hdr_bytes[1][7] && (crc_rcvd == crc_calc));
                    end
                end
                default: ;
            endcase
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            err_cnt++;
        end
    endtask

    task automatic compare_record(input section_record_t want);
        check_field("kind", 16'(want.kind), 16'(m_tuser));
        check_field("payload_byte", 16'(want.payload_byte), 16'(m_tdata[7:0]));
        check_field("table_id", 16'(want.table_id), 16'(m_tdata[15:8]));
        check_field("syntax_flag", 16'(want.syntax_flag), 16'(m_tdata[16]));
        check_field("private_flag", 16'(want.private_flag), 16'(m_tdata[17]));
        check_field("payload_length", 16'(want.payload_length), 16'(m_tdata[29:18]));
        check_field("table_number", want.table_number, m_tdata[45:30]);
        check_field("version", 16'(want.version), 16'(m_tdata[50:46]));
        check_field("current_next", 16'(want.current_next), 16'(m_tdata[51]));
        check_field("section_number", 16'(want.section_number), 16'(m_tdata[59:52]));
        check_field("last_section_number", 16'(want.last_section_number),
                    16'(m_tdata[67:60]));
        check_field("crc_ok", 16'(want.crc_ok), 16'(m_tdata[68]));
        check_field("tdata_pad", 16'h0, 16'(m_tdata[71:69]));
    endtask

    // sample both channels at the clock edge: requests first, then results
    always @(posedge aclk) begin
        section_record_t want;
        if (!aresetn) begin
            parse_phase = psc_pkg::PH_IDLE;
            byte_cnt    = 12'd0;
            for (int k = 0; k < 8; k++) hdr_bytes[k] = 8'h00;
            sec_length  = 12'd0;
            crc_calc    = psc_pkg::CRC_INIT;
            crc_rcvd    = 32'h0;
            due_records.delete();
        end else begin
            if (s_tvalid && s_tready)
                parse_byte(s_tdata, s_tuser);
            if (m_tvalid && m_tready) begin
                if (due_records.size() == 0) begin
                    $error("unexpected result: kind %0d, tdata 0x%0h", m_tuser, m_tdata);
                    err_cnt++;
                end else begin
                    want = due_records.pop_front();
                    compare_record(want);
                end
            end
        end
        outstanding <= due_records.size();
        mismatches  <= err_cnt;
    end

endmodule

/* dv/tb_psi_section_header_crc_check.sv */
// top of the section parser testbench: clock, reset, byte stimulus, backpressure, verdict
// depends on psc_pkg, psi_section_checker.sv and the parser rtl
`timescale 1ns / 1ps

module tb_psi_section_header_crc_check;

    localparam int CLOCK_LIMIT = 300000;
    localparam int LONG_HOLD   = 400;
    localparam int PHASE_ITEMS = 80;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = 1'b0;
    logic        m_tready = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [71:0] m_tdata;
    wire  [1:0]  m_tuser;

    int mismatches;
    int outstanding;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;
    bit long_hold_req  = 1'b0;

    psi_section_header_crc_check dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    psi_section_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // 50 MHz clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CLOCK_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // offer one byte, with random idle cycles ahead of it, and wait for the request to go
    task automatic push_byte(input logic [7:0] d, input logic st);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= st;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    // hold off requests until every predicted result has come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    // header bytes packed with byte k at bits 8k+7..8k; cut > 0 truncates the section
    task automatic send_section(input logic [63:0] hdr, input bit crc_good, input int cut);
        logic [7:0]  stream_q[$];
        logic [7:0]  b;
        logic [31:0] crc;
        int          sec_len;
        int          n;
        crc     = psc_pkg::CRC_INIT;
        sec_len = int'({hdr[11:8], hdr[23:16]});
        for (int k = 0; k < 8; k++) begin
            stream_q.push_back(hdr[8*k +: 8]);
            crc = section_tb_pkg::crc_next(crc, hdr[8*k +: 8]);
        end
        if (sec_len >= int'(psc_pkg::HDR_CRC_BYTES)) begin
            repeat (sec_len - int'(psc_pkg::HDR_CRC_BYTES)) begin
                b = 8'($urandom);
                stream_q.push_back(b);
                crc = section_tb_pkg::crc_next(crc, b);
            end
            if (!crc_good)
                crc = crc ^ (32'h1 << $urandom_range(31));
            stream_q.push_back(crc[31:24]);
            stream_q.push_back(crc[23:16]);
            stream_q.push_back(crc[15:8]);
            stream_q.push_back(crc[7:0]);
        end
        n = (cut > 0 && cut < stream_q.size()) ? cut : stream_q.size();
        for (int k = 0; k < n; k++)
            push_byte(stream_q[k], k == 0);
    endtask

    function automatic logic [63:0] random_header(input int sec_len, input bit syntax);
        logic [63:0] h;
        logic [11:0] len;
        h       = {$urandom, $urandom};
        len     = 12'(sec_len);
        h[15]   = syntax;
        h[11:8] = len[11:8];
        h[23:16] = len[7:0];
        return h;
    endfunction

    // mostly well-formed sections, some short, some truncated, a little idle noise
    task automatic send_random_section();
        int pick;
        int sec_len;
        int cut;
        int min_len;
        min_len = int'(psc_pkg::HDR_CRC_BYTES);
        pick = $urandom_range(99);
        cut  = 0;
        if ($urandom_range(99) < 8)
            repeat ($urandom_range(1, 4)) push_byte(8'($urandom), 1'b0);
        if (pick < 8) begin
            sec_len = $urandom_range(8);
        end else if (pick < 14) begin
            sec_len = min_len;
        end else if (pick < 82) begin
            sec_len = min_len + int'($urandom_range(1, 24));
        end else if (pick < 90) begin
            sec_len = min_len + int'($urandom_range(25, 300));
        end else begin
            sec_len = min_len + int'($urandom_range(30));
            cut     = $urandom_range(1, sec_len + 2);
        end
        send_section(random_header(sec_len, $urandom_range(99) < 85),
                     $urandom_range(99) < 80, cut);
    endtask

    // stimulus and verdict
    initial begin
        int phase_start;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // bytes without a start while idle are dropped
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        // all-zero header, length zero
        send_section(64'h0, 1'b1, 0);
        // length one short of the minimum, other fields all ones
        send_section(64'hFFFF_FFFF_FF08_F0FF, 1'b1, 0);
        // section cut off by a new start
        push_byte(8'hAB, 1'b1);
        push_byte(8'hB0, 1'b0);
        // empty payload, crc right after the header
        send_section(64'hFFFF_FFFF_FF09_F0FF, 1'b1, 0);
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 60;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 60;
                end
                default: begin
                    send_idle_pct  = 32;
                    recv_stall_pct = 32;
                end
            endcase
            // largest section length, cut short after a few payload bytes
            if (p == 0)
                send_section(random_header(4095, 1'b1), 1'b1, 20);
            // long hold-off on the result side while bytes keep coming
            if (p == 2) begin
                long_hold_req = 1'b1;
                send_section(random_header(int'(psc_pkg::HDR_CRC_BYTES) + 60, 1'b1),
                             1'b1, 0);
            end
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
                send_random_section();
            wait_drained();
        end

        repeat (20) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
